FILE: src/sample_moving_average_defines.svh
// ----------------------------------------------------------------------------
// sample_moving_average_defines.svh
// Assertion macros shared by the moving average block.
// ----------------------------------------------------------------------------
`ifndef SAMPLE_MOVING_AVERAGE_DEFINES_SVH
`define SAMPLE_MOVING_AVERAGE_DEFINES_SVH

// same-cycle implication, checked on aclk outside reset
`define SMA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SMA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/sma_pkg.sv
// ----------------------------------------------------------------------------
// sma_pkg
// Shared types and defaults for the sample moving average block.
// ----------------------------------------------------------------------------
package sma_pkg;

    localparam int MAX_WINDOW_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 12;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_LOAD,
        ST_DIVIDE,
        ST_HOLD
    } sma_state_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;     // capture sample
        logic update;     // ring write, sum and position update
        logic div_load;   // load divider with sum + N/2
        logic div_step;   // one quotient bit
        logic out_load;   // quotient into output register
    } sma_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic div_last;   // current divide step is the final one
    } sma_status_t;

endpackage

FILE: src/sma_ctrl.sv
// ----------------------------------------------------------------------------
// sma_ctrl
// Sequencer for the moving average: accept, update, divide, hand off.
// ----------------------------------------------------------------------------
module sma_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output sma_pkg::sma_cmd_t    cmd,
    input  sma_pkg::sma_status_t status
);
    import sma_pkg::*;

    sma_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                cmd.div_load = 1'b1;
                state_next   = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                // output register free, or its transfer completes this cycle
                if (!out_valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

FILE: src/sma_datapath.sv
// ----------------------------------------------------------------------------
// sma_datapath
// Sample ring, running sum, window length and bit-serial divider.
// ----------------------------------------------------------------------------
module sma_datapath #(
    parameter int MAX_WINDOW  = sma_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = sma_pkg::SAMPLE_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  sma_pkg::sma_cmd_t               cmd,
    output sma_pkg::sma_status_t            status,
    input  logic                            cfg_wen,
    input  logic [$clog2(MAX_WINDOW+1)-1:0] cfg_wdata,
    input  logic [SAMPLE_BITS-1:0]          sample,
    output logic [SAMPLE_BITS-1:0]          average
);
    import sma_pkg::*;

    localparam int LEN_BITS  = $clog2(MAX_WINDOW + 1);
    localparam int POS_BITS  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int SUM_BITS  = SAMPLE_BITS + $clog2(MAX_WINDOW);
    localparam int DIV_BITS  = SUM_BITS + 1;
    localparam int HI_BITS   = DIV_BITS - SAMPLE_BITS;
    localparam int PROD_BITS = SAMPLE_BITS + LEN_BITS;
    localparam int STEP_BITS = $clog2(SAMPLE_BITS);

    logic [SAMPLE_BITS-1:0] ring_mem [MAX_WINDOW];
    logic [SAMPLE_BITS-1:0] rd_data_reg;

    logic [LEN_BITS-1:0]    len_reg, len_next;
    logic                   primed_reg, primed_next;
    logic                   wrapped_reg, wrapped_next;
    logic [POS_BITS-1:0]    pos_reg, pos_next;
    logic [SUM_BITS-1:0]    sum_reg, sum_next;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [SAMPLE_BITS-1:0] prime_val_reg;
    logic [LEN_BITS-1:0]    rem_reg;
    logic [SAMPLE_BITS-1:0] quo_reg;
    logic [STEP_BITS-1:0]   step_reg;
    logic [SAMPLE_BITS-1:0] avg_reg;

    // window length write
    logic [LEN_BITS-1:0] cfg_clamped;
    always_comb begin
        priority if (cfg_wdata == '0) begin
            cfg_clamped = LEN_BITS'(1);
        end else if (cfg_wdata > LEN_BITS'(MAX_WINDOW)) begin
            cfg_clamped = LEN_BITS'(MAX_WINDOW);
        end else begin
            cfg_clamped = cfg_wdata;
        end
    end

    // update step; the first sample after priming stands in for every entry
    // not yet rewritten, tracked by wrapped_reg instead of a fill sweep
    logic [POS_BITS-1:0]    wr_addr;
    logic [LEN_BITS-1:0]    pos_inc;
    logic                   wrap;
    logic [SAMPLE_BITS-1:0] old_entry;
    logic [PROD_BITS-1:0]   fill_prod;

    assign wr_addr   = primed_reg ? pos_reg : '0;
    assign pos_inc   = LEN_BITS'(wr_addr) + LEN_BITS'(1);
    assign wrap      = (pos_inc >= len_reg);
    assign old_entry = wrapped_reg ? rd_data_reg : prime_val_reg;
    assign fill_prod = PROD_BITS'(sample_reg) * PROD_BITS'(len_reg);

    // ring contents are read continuously at the write position
    always_ff @(posedge aclk) begin
        if (cmd.update) begin
            ring_mem[wr_addr] <= sample_reg;
        end
        rd_data_reg <= ring_mem[pos_reg];
    end

    always_comb begin
        len_next     = len_reg;
        primed_next  = primed_reg;
        wrapped_next = wrapped_reg;
        pos_next     = pos_reg;
        sum_next     = sum_reg;
        if (cfg_wen && (cfg_wdata != len_reg)) begin
            len_next    = cfg_clamped;
            primed_next = 1'b0;
        end
        if (cmd.update) begin
            primed_next  = 1'b1;
            pos_next     = wrap ? '0 : pos_inc[POS_BITS-1:0];
            wrapped_next = primed_reg ? (wrapped_reg | wrap) : wrap;
            if (primed_reg) begin
                sum_next = sum_reg - SUM_BITS'(old_entry) + SUM_BITS'(sample_reg);
            end else begin
                sum_next = fill_prod[SUM_BITS-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg     <= LEN_BITS'(MAX_WINDOW);
            primed_reg  <= 1'b0;
            wrapped_reg <= 1'b0;
            pos_reg     <= '0;
            sum_reg     <= '0;
        end else begin
            len_reg     <= len_next;
            primed_reg  <= primed_next;
            wrapped_reg <= wrapped_next;
            pos_reg     <= pos_next;
            sum_reg     <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            sample_reg <= sample;
        end
        if (cmd.update && !primed_reg) begin
            prime_val_reg <= sample_reg;
        end
    end

    // restoring divider: (sum + N/2) / N, one quotient bit per cycle.
    // The quotient fits SAMPLE_BITS, so the upper dividend bits start below N.
    logic [DIV_BITS-1:0]  dividend;
    logic [HI_BITS-1:0]   dvd_hi;
    logic [LEN_BITS:0]    trial;
    logic [LEN_BITS:0]    trial_diff;
    logic                 trial_ge;

    assign dividend   = DIV_BITS'(sum_reg) + DIV_BITS'(len_reg >> 1);
    assign dvd_hi     = dividend[DIV_BITS-1:SAMPLE_BITS];
    assign trial      = {rem_reg, quo_reg[SAMPLE_BITS-1]};
    assign trial_ge   = (trial >= {1'b0, len_reg});
    assign trial_diff = trial - {1'b0, len_reg};

    always_ff @(posedge aclk) begin
        if (cmd.div_load) begin
            rem_reg <= dvd_hi[LEN_BITS-1:0];
            quo_reg <= dividend[SAMPLE_BITS-1:0];
        end else if (cmd.div_step) begin
            rem_reg <= trial_ge ? trial_diff[LEN_BITS-1:0] : trial[LEN_BITS-1:0];
            quo_reg <= {quo_reg[SAMPLE_BITS-2:0], trial_ge};
        end
        if (cmd.out_load) begin
            avg_reg <= quo_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
        end else if (cmd.div_load) begin
            step_reg <= '0;
        end else if (cmd.div_step) begin
            step_reg <= step_reg + STEP_BITS'(1);
        end
    end

    assign status.div_last = (step_reg == STEP_BITS'(SAMPLE_BITS - 1));
    assign average         = avg_reg;

endmodule

FILE: src/sample_moving_average.sv
// ----------------------------------------------------------------------------
// sample_moving_average
// Rounded mean of the last N sensor samples, N set by the window length.
//
//   channel  | dir | handshake         | payload
//   ---------+-----+-------------------+---------------------------
//   s_       | in  | s_tvalid/s_tready | s_tdata: sample
//   m_       | out | m_tvalid/m_tready | m_tdata: average
//   cfg_     | in  | cfg_wen           | cfg_wdata: window_length
//
// One item at a time: after the transfer come the update, divider load, divide
// and hold states; the divider yields one quotient bit per cycle.
// The next sample is taken as soon as the result sits in the output register.
// A stalled output holds the result in the hold state until it is taken.
// No clearing pass after reset; the ring is primed by the first sample.
// ----------------------------------------------------------------------------
`include "sample_moving_average_defines.svh"

module sample_moving_average #(
    parameter int MAX_WINDOW  = sma_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = sma_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,   // sample
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]     m_tdata,   // average
    input  logic                                 cfg_wen,
    input  logic [$clog2(MAX_WINDOW+1)-1:0]      cfg_wdata  // window_length
);
    import sma_pkg::*;

    localparam int DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;

    sma_cmd_t               cmd;
    sma_status_t            status;
    logic [SAMPLE_BITS-1:0] average;

    sma_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    sma_datapath #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .sample    (s_tdata[SAMPLE_BITS-1:0]),
        .average   (average)
    );

    assign m_tdata = DATA_BITS'(average);

    `SMA_ASSERT_NXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "second sample taken while busy")
    `SMA_ASSERT_IMP(a_no_overwrite, cmd.out_load, !m_tvalid || m_tready, "pending result overwritten")
    `SMA_ASSERT_IMP(a_cmd_onehot, 1'b1, $onehot0(cmd), "more than one datapath command")

endmodule

FILE: sim/sample_moving_average_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sample_moving_average_tb
// Streams sensor samples into the moving average block and compares every
// average against a running-sum predictor. Window lengths are changed between
// bursts, including zero, oversize and unchanged writes. Both stream sides
// idle at random; the receiver also holds off once for a long stretch.
// ----------------------------------------------------------------------------
module sample_moving_average_tb;
    import sma_pkg::*;

    localparam int DATA_W    = ((SAMPLE_BITS_DEF + 7) / 8) * 8;
    localparam int LEN_W     = $clog2(MAX_WINDOW_DEF + 1);
    localparam int SUM_W     = SAMPLE_BITS_DEF + $clog2(MAX_WINDOW_DEF) + 1;
    localparam int LATENCY   = SAMPLE_BITS_DEF + 4;
    localparam int RANDOM_N  = 1450;
    localparam int HOLD_AT   = 200;
    localparam int HOLD_LEN  = 300;

    // Running-sum model of the averager plus the queue of pending averages.
    class avg_scoreboard;
        logic [SAMPLE_BITS_DEF-1:0] ring [MAX_WINDOW_DEF];
        logic [SUM_W-1:0]           total;
        int                         slot;
        bit                         primed;
        int                         window_n;
        logic [SAMPLE_BITS_DEF-1:0] pending_averages [$];
        int                         fail_count;

        function new();
            foreach (ring[i]) ring[i] = '0;
            total      = '0;
            slot       = 0;
            primed     = 0;
            window_n   = MAX_WINDOW_DEF;
            fail_count = 0;
        endfunction

        function void write_length(logic [LEN_W-1:0] value);
            int v;
            v = int'(value);
            if (v == window_n)
                return;
            if (v < 1)
                v = 1;
            else if (v > MAX_WINDOW_DEF)
                v = MAX_WINDOW_DEF;
            window_n = v;
            primed   = 0;
        endfunction

        function void note_sample(logic [SAMPLE_BITS_DEF-1:0] s);
            int mean;
            if (!primed) begin
                for (int i = 0; i < window_n; i++)
                    ring[i] = s;
                total  = SUM_W'(s) * SUM_W'(window_n);
                slot   = 0;
                primed = 1;
            end
            if (slot >= window_n)
                slot = 0;
            total      = total - SUM_W'(ring[slot]) + SUM_W'(s);
            ring[slot] = s;
            slot       = (slot + 1 >= window_n) ? 0 : slot + 1;
            mean       = (int'(total) + window_n / 2) / window_n;
            pending_averages.push_back(SAMPLE_BITS_DEF'(mean));
        endfunction

        function void check_average(logic [SAMPLE_BITS_DEF-1:0] actual);
            logic [SAMPLE_BITS_DEF-1:0] want;
            if (pending_averages.size() == 0) begin
                $error("average: unexpected transfer, actual %0d", actual);
                fail_count++;
                return;
            end
            want = pending_averages.pop_front();
            if (actual !== want) begin
                $error("average: expected %0d, actual %0d", want, actual);
                fail_count++;
            end
        endfunction

        function void check_leftovers();
            if (pending_averages.size() != 0) begin
                $error("average: %0d expected values never arrived",
                       pending_averages.size());
                fail_count++;
            end
        endfunction
    endclass

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata;   // sample
    logic              m_tvalid;
    logic              m_tready;
    logic [DATA_W-1:0] m_tdata;   // average
    logic              cfg_wen;
    logic [LEN_W-1:0]  cfg_wdata; // window_length

    avg_scoreboard sb = new();
    bit            back_to_back = 0;
    int            samples_sent = 0;
    int            averages_taken = 0;

    sample_moving_average u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Monitors: values read right after the edge are the pre-edge values.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_wen)
                sb.write_length(cfg_wdata);
            if (s_tvalid && s_tready)
                sb.note_sample(s_tdata[SAMPLE_BITS_DEF-1:0]);
            if (m_tvalid && m_tready)
                sb.check_average(m_tdata[SAMPLE_BITS_DEF-1:0]);
        end
    end

    // Receiver: random stalls, one long hold-off so the block backs up.
    initial begin
        int stall;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = back_to_back ? 0 : $urandom_range(0, 7);
            if (averages_taken == HOLD_AT)
                stall = HOLD_LEN;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            averages_taken++;
        end
    end

    task automatic send_sample(input logic [SAMPLE_BITS_DEF-1:0] s);
        int gap;
        gap = back_to_back ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= DATA_W'(s);
        do @(posedge aclk); while (!s_tready);
        samples_sent++;
    endtask

    // Sender stops and waits until every expected average has come back.
    task automatic wait_drained();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        do begin
            @(posedge aclk);
            guard++;
        end while (sb.pending_averages.size() != 0 && guard < 20000);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    task automatic set_window(input logic [LEN_W-1:0] value);
        wait_drained();
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wen   <= 1'b0;
    endtask

    function automatic logic [LEN_W-1:0] pick_length();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return LEN_W'(MAX_WINDOW_DEF);
            2:       return LEN_W'($urandom_range(MAX_WINDOW_DEF + 1, 2**LEN_W - 1));
            3:       return LEN_W'(sb.window_n);
            4:       return LEN_W'($urandom_range(0, 2**LEN_W - 1));
            default: return LEN_W'($urandom_range(1, 12));
        endcase
    endfunction

    function automatic logic [SAMPLE_BITS_DEF-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return SAMPLE_BITS_DEF'($urandom_range(2**SAMPLE_BITS_DEF - 96,
                                                            2**SAMPLE_BITS_DEF - 1));
            3:       return SAMPLE_BITS_DEF'($urandom_range(0, 15));
            default: return SAMPLE_BITS_DEF'($urandom_range(0, 2**SAMPLE_BITS_DEF - 1));
        endcase
    endfunction

    initial begin
        int burst;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_wen   <= 1'b0;
        cfg_wdata <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset length, first sample primes the full window
        send_sample(12'hFFF);
        send_sample(12'h000);
        send_sample(12'hFFF);
        send_sample(12'h001);
        send_sample(12'h800);
        // unchanged length keeps the window primed
        set_window(LEN_W'(MAX_WINDOW_DEF));
        send_sample(12'h000);
        send_sample(12'hFFF);
        // oversize value clamps to the maximum length but still re-primes
        set_window(7'd100);
        send_sample(12'h800);
        send_sample(12'h7FF);
        // zero length behaves as one
        set_window(7'd0);
        send_sample(12'hFFF);
        send_sample(12'h000);
        send_sample(12'hAAA);
        send_sample(12'h555);
        set_window(7'd127);
        send_sample(12'h001);
        send_sample(12'hFFE);
        // half-up rounding on short windows
        set_window(7'd2);
        send_sample(12'hFFF);
        send_sample(12'h000);
        send_sample(12'hFFF);
        set_window(7'd3);
        send_sample(12'h001);
        send_sample(12'h000);
        send_sample(12'h000);

        while (samples_sent < RANDOM_N) begin
            if ($urandom_range(0, 3) != 0)
                set_window(pick_length());
            else
                wait_drained();
            back_to_back = ($urandom_range(0, 4) == 0);
            burst = $urandom_range(10, 80);
            repeat (burst) send_sample(pick_sample());
        end
        back_to_back = 0;

        wait_drained();
        sb.check_leftovers();
        if (sb.fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/sma_pkg.sv
src/sma_ctrl.sv
src/sma_datapath.sv
src/sample_moving_average.sv
sim/sample_moving_average_tb.sv
